// ----- rtl/nms_pkg.sv -----
// Shared types and constants for the box non-maximum suppression engine.
// No dependencies; nms_ctrl, nms_dpath and box_nms_engine import this package.
`default_nettype none
package nms_pkg;

   localparam int COORD_W = 16;
   localparam int SCORE_W = 16;
   localparam int AREA_W  = 32;
   localparam int THR_W   = 16;
   localparam int KIDX_W  = 6;

   localparam logic [THR_W-1:0] THR_RESET = 16'd19661;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RANK_RD,
      ST_RANK_KEY,
      ST_RANK_SCAN,
      ST_RANK_WR,
      ST_SUP_RD,
      ST_SUP_CHK,
      ST_SUP_KEEP,
      ST_SUP_SCAN,
      ST_FLUSH
   } nms_state_type;

   // One stored box: score, area and corners
   typedef struct packed {
      logic        [SCORE_W-1:0] score;
      logic        [AREA_W-1:0]  area;
      logic signed [COORD_W-1:0] bottom;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] top;
      logic signed [COORD_W-1:0] left;
   } box_rec_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic req_ready;
      logic load;
      logic i_clr;
      logic i_inc;
      logic rd_box_i;
      logic rd_ord;
      logic rd_box_a;
      logic sort_key;
      logic scan_en;
      logic scan_sup;
      logic rank_wr;
      logic keep;
      logic flush;
   } nms_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last_in;
      logic scan_done;
      logic i_last;
      logic a_sup;
      logic can_push;
      logic pend_vld;
   } nms_sts_type;

   // Extent between two signed corners, zero when reversed
   function automatic logic [COORD_W-1:0] span16(input logic signed [COORD_W-1:0] lo,
                                                 input logic signed [COORD_W-1:0] hi);
      logic signed [COORD_W:0] diff;
      diff = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
      return (hi > lo) ? diff[COORD_W-1:0] : '0;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/nms_ifs.sv -----
// Valid/ready channel interfaces for request, response and register write.
// Depends on nothing; payload widths are fixed by the channel format.
`default_nettype none
interface nms_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] box_left;
   logic signed [15:0] box_top;
   logic signed [15:0] box_right;
   logic signed [15:0] box_bottom;
   logic        [15:0] box_score;
   logic               last_box;
   modport source (output valid, box_left, box_top, box_right, box_bottom, box_score,
                   last_box, input ready);
   modport sink (input valid, box_left, box_top, box_right, box_bottom, box_score,
                 last_box, output ready);
endinterface

interface nms_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] kept_index;
   logic       last_kept;
   logic       overflow;
   modport source (output valid, kept_index, last_kept, overflow, input ready);
   modport sink (input valid, kept_index, last_kept, overflow, output ready);
endinterface

interface nms_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] iou_threshold;
   modport source (output valid, iou_threshold, input ready);
   modport sink (input valid, iou_threshold, output ready);
endinterface
`default_nettype wire

// ----- rtl/nms_ctrl.sv -----
// Sequencer for load, rank sort, suppression sweep and result flush.
// Depends on nms_pkg; drives the datapath through nms_cmd_type.
`default_nettype none
module nms_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  nms_pkg::nms_sts_type sts,
   output nms_pkg::nms_cmd_type cmd
);
   import nms_pkg::*;

   nms_state_type state_ff, state_in;

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_LOAD;
         ST_LOAD:      state_in = sts.last_in ? ST_RANK_RD : ST_IDLE;
         ST_RANK_RD:   state_in = ST_RANK_KEY;
         ST_RANK_KEY:  state_in = ST_RANK_SCAN;
         ST_RANK_SCAN: if (sts.scan_done) state_in = ST_RANK_WR;
         ST_RANK_WR:   state_in = sts.i_last ? ST_SUP_RD : ST_RANK_RD;
         ST_SUP_RD:    state_in = ST_SUP_CHK;
         ST_SUP_CHK: begin
            if (!sts.a_sup) state_in = ST_SUP_KEEP;
            else            state_in = sts.i_last ? ST_FLUSH : ST_SUP_RD;
         end
         ST_SUP_KEEP:  if (!sts.pend_vld || sts.can_push) state_in = ST_SUP_SCAN;
         ST_SUP_SCAN: begin
            if (sts.scan_done) state_in = sts.i_last ? ST_FLUSH : ST_SUP_RD;
         end
         ST_FLUSH:     if (sts.can_push) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:      cmd.req_ready = 1'b1;
         ST_LOAD: begin
            cmd.load  = 1'b1;
            cmd.i_clr = 1'b1;
         end
         ST_RANK_RD:   cmd.rd_box_i = 1'b1;
         ST_RANK_KEY:  cmd.sort_key = 1'b1;
         ST_RANK_SCAN: cmd.scan_en  = 1'b1;
         ST_RANK_WR: begin
            cmd.rank_wr = 1'b1;
            cmd.i_clr   = sts.i_last;
            cmd.i_inc   = !sts.i_last;
         end
         ST_SUP_RD:    cmd.rd_ord = 1'b1;
         ST_SUP_CHK: begin
            cmd.rd_box_a = !sts.a_sup;
            cmd.i_inc    = sts.a_sup && !sts.i_last;
         end
         ST_SUP_KEEP:  cmd.keep = !sts.pend_vld || sts.can_push;
         ST_SUP_SCAN: begin
            cmd.scan_en  = 1'b1;
            cmd.scan_sup = 1'b1;
            cmd.i_inc    = sts.scan_done && !sts.i_last;
         end
         ST_FLUSH:     cmd.flush = sts.can_push;
         default:      cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/nms_dpath.sv -----
// Box stores, rank sort counters, IoU pipeline, suppression flags, output register.
// Depends on nms_pkg and nms_ifs; steered by nms_ctrl commands.
`default_nettype none
module nms_dpath #(
   parameter int MAX_BOXES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  nms_pkg::nms_cmd_type cmd,
   output nms_pkg::nms_sts_type sts,
   nms_req_if.sink              req_bus,
   nms_rsp_if.source            rsp_bus,
   nms_csr_if.sink              csr_bus
);
   import nms_pkg::*;

   localparam int IDX_W = $clog2(MAX_BOXES);
   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam int USUM_W = AREA_W + 1;
   localparam int PROD_W = USUM_W + THR_W;

   box_rec_type in_ff;
   logic        in_last_ff;
   logic [THR_W-1:0] thr_ff;
   logic [CNT_W-1:0] cnt_ff, j_ff;
   logic             ovf_ff;
   logic [IDX_W-1:0] i_ff, rank_ff, ord_rd_ff;
   logic [SCORE_W-1:0] key_ff;
   box_rec_type box_mem [MAX_BOXES];
   logic [IDX_W-1:0] ord_mem [MAX_BOXES];
   box_rec_type box_rd_ff, a_rec_ff;
   logic [MAX_BOXES-1:0] sup_ff;
   logic va_ff, vb_ff, vc_ff;
   logic [IDX_W-1:0] jda_ff, jdb_ff, jdc_ff;
   logic [AREA_W-1:0] inter_b_ff, inter_c_ff;
   logic [USUM_W-1:0] asum_ff;
   logic [PROD_W-1:0] prod_ff;
   logic pend_vld_ff;
   logic [IDX_W-1:0] pend_idx_ff;
   logic rsp_vld_ff, rsp_last_ff, rsp_ovf_ff;
   logic [KIDX_W-1:0] rsp_idx_ff;

   logic req_acc, full, issue, rd_en, can_push, push, rank_hit, sup_hit;
   logic [IDX_W-1:0] rd_addr;
   logic [COORD_W-1:0] iw, ih;
   logic signed [COORD_W-1:0] ol, ot, orr, ob;
   logic [USUM_W-1:0] uni;
   box_rec_type new_rec;

   assign req_acc  = req_bus.valid && cmd.req_ready && !reset;
   assign full     = (cnt_ff == CNT_W'(MAX_BOXES));
   assign issue    = cmd.scan_en && (j_ff != cnt_ff);
   assign can_push = !rsp_vld_ff || rsp_bus.ready;
   assign push     = (cmd.keep && pend_vld_ff) || cmd.flush;

   assign req_bus.ready      = cmd.req_ready && !reset;
   assign csr_bus.ready      = !reset;
   assign rsp_bus.valid      = rsp_vld_ff;
   assign rsp_bus.kept_index = rsp_idx_ff;
   assign rsp_bus.last_kept  = rsp_last_ff;
   assign rsp_bus.overflow   = rsp_ovf_ff;

   assign sts.last_in   = in_last_ff;
   assign sts.scan_done = (j_ff == cnt_ff) && !va_ff && !vb_ff && !vc_ff;
   assign sts.i_last    = ((CNT_W'(i_ff) + CNT_W'(1)) == cnt_ff);
   assign sts.a_sup     = sup_ff[ord_rd_ff];
   assign sts.can_push  = can_push;
   assign sts.pend_vld  = pend_vld_ff;

   // Hold the incoming request
   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_ff.left   <= req_bus.box_left;
         in_ff.top    <= req_bus.box_top;
         in_ff.right  <= req_bus.box_right;
         in_ff.bottom <= req_bus.box_bottom;
         in_ff.score  <= req_bus.box_score;
         in_ff.area   <= '0;
         in_last_ff   <= req_bus.last_box;
      end
   end

   // Build the stored record with its area
   always_comb begin
      new_rec      = in_ff;
      new_rec.area = AREA_W'(span16(in_ff.left, in_ff.right))
                   * AREA_W'(span16(in_ff.top, in_ff.bottom));
   end

   // Write and read the box store
   always_comb begin
      priority if (cmd.rd_box_i) rd_addr = i_ff;
      else if (cmd.rd_box_a)     rd_addr = ord_rd_ff;
      else                       rd_addr = j_ff[IDX_W-1:0];
   end
   assign rd_en = cmd.rd_box_i || cmd.rd_box_a || issue;

   always_ff @(posedge clock) begin
      if (cmd.load && !full) begin
         box_mem[cnt_ff[IDX_W-1:0]] <= new_rec;
      end
      if (rd_en) begin
         box_rd_ff <= box_mem[rd_addr];
      end
   end

   // Write and read the score order store
   always_ff @(posedge clock) begin
      if (cmd.rank_wr) begin
         ord_mem[rank_ff] <= i_ff;
      end
      if (cmd.rd_ord) begin
         ord_rd_ff <= ord_mem[i_ff];
      end
   end

   // Latch sort key and kept box
   always_ff @(posedge clock) begin
      if (cmd.sort_key) key_ff <= box_rd_ff.score;
      if (cmd.keep)     a_rec_ff <= box_rd_ff;
   end

   // Rank compare: higher score, or equal score at lower load index
   assign rank_hit = va_ff && cmd.scan_en && !cmd.scan_sup &&
                     ((box_rd_ff.score > key_ff) ||
                      ((box_rd_ff.score == key_ff) && (jda_ff < i_ff)));

   // Intersection of the kept box with the scanned box
   always_comb begin
      ol  = (a_rec_ff.left > box_rd_ff.left) ? a_rec_ff.left : box_rd_ff.left;
      ot  = (a_rec_ff.top > box_rd_ff.top) ? a_rec_ff.top : box_rd_ff.top;
      orr = (a_rec_ff.right < box_rd_ff.right) ? a_rec_ff.right : box_rd_ff.right;
      ob  = (a_rec_ff.bottom < box_rd_ff.bottom) ? a_rec_ff.bottom : box_rd_ff.bottom;
      iw  = span16(ol, orr);
      ih  = span16(ot, ob);
   end

   assign uni     = asum_ff - USUM_W'(inter_b_ff);
   assign sup_hit = vc_ff && ({inter_c_ff, 16'd0} > (AREA_W + 16)'(prod_ff));

   // Advance the IoU pipeline
   always_ff @(posedge clock) begin
      inter_b_ff <= AREA_W'(iw) * AREA_W'(ih);
      asum_ff    <= USUM_W'(a_rec_ff.area) + USUM_W'(box_rd_ff.area);
      inter_c_ff <= inter_b_ff;
      prod_ff    <= PROD_W'(thr_ff) * PROD_W'(uni);
      jda_ff     <= j_ff[IDX_W-1:0];
      jdb_ff     <= jda_ff;
      jdc_ff     <= jdb_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= THR_RESET;
         cnt_ff      <= '0;
         ovf_ff      <= 1'b0;
         i_ff        <= '0;
         j_ff        <= '0;
         rank_ff     <= '0;
         va_ff       <= 1'b0;
         vb_ff       <= 1'b0;
         vc_ff       <= 1'b0;
         sup_ff      <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (csr_bus.valid) thr_ff <= csr_bus.iou_threshold;

         // count boxes, flag drops
         if (cmd.flush) begin
            cnt_ff <= '0;
            ovf_ff <= 1'b0;
         end else if (cmd.load) begin
            if (full) ovf_ff <= 1'b1;
            else      cnt_ff <= cnt_ff + CNT_W'(1);
         end

         if (cmd.i_clr)      i_ff <= '0;
         else if (cmd.i_inc) i_ff <= i_ff + IDX_W'(1);

         if (cmd.sort_key || cmd.keep) j_ff <= '0;
         else if (issue)               j_ff <= j_ff + CNT_W'(1);

         if (cmd.sort_key)  rank_ff <= '0;
         else if (rank_hit) rank_ff <= rank_ff + IDX_W'(1);

         va_ff <= issue;
         vb_ff <= va_ff && cmd.scan_sup;
         vc_ff <= vb_ff;

         // mark overlapping boxes, drop all marks at end of set
         if (cmd.flush)    sup_ff <= '0;
         else if (sup_hit) sup_ff[jdc_ff] <= 1'b1;

         if (cmd.flush)     pend_vld_ff <= 1'b0;
         else if (cmd.keep) pend_vld_ff <= 1'b1;

         if (push)               rsp_vld_ff <= 1'b1;
         else if (rsp_bus.ready) rsp_vld_ff <= 1'b0;
      end
   end

   // Pending kept index and response payload
   always_ff @(posedge clock) begin
      if (cmd.keep) pend_idx_ff <= ord_rd_ff;
      if (push) begin
         rsp_idx_ff  <= KIDX_W'(pend_idx_ff);
         rsp_last_ff <= cmd.flush;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/box_nms_engine.sv -----
// Top level of the greedy non-maximum suppression engine.
// Depends on nms_pkg, nms_ifs, nms_ctrl and nms_dpath.
//
//  Port     | Dir | Carries
//  req_bus  | in  | one box: corners, score, last_box
//  rsp_bus  | out | one kept index with last_kept and overflow
//  csr_bus  | in  | iou_threshold write, ready whenever not in reset
//
// Each request is registered, then written with its area, and no new box is taken
// until that write is done. After last_box the rank sort and the suppression sweep
// are bound by the single read port of the box store. No clearing pass follows
// reset. A stalled response holds the sequencer only when a new kept index must
// be pushed.
`default_nettype none
module box_nms_engine #(
   parameter int MAX_BOXES = 64
) (
   input  logic      clock,
   input  logic      reset,
   nms_req_if.sink   req_bus,
   nms_rsp_if.source rsp_bus,
   nms_csr_if.sink   csr_bus
);
   import nms_pkg::*;

   nms_cmd_type cmd;
   nms_sts_type sts;

   nms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   nms_dpath #(.MAX_BOXES(MAX_BOXES)) u_dpath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .sts     (sts),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

endmodule
`default_nettype wire
